>>> design/vna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vna_pkg;

  localparam int NUM_VERTS   = 1024;
  localparam int IDX_W       = 10;
  localparam int VIDX_W      = $clog2(NUM_VERTS);
  localparam int MAX_CORNERS = 8;
  localparam int CIDX_W      = $clog2(MAX_CORNERS);
  localparam int CCNT_W      = $clog2(MAX_CORNERS + 1);
  localparam int COORD_W     = 16;
  localparam int EDGE_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * EDGE_W;
  localparam int CROSS_W     = PROD_W + 2;
  localparam int ACC_W       = 24;
  localparam int N_W         = 16;
  localparam int Q_FRAC      = 14;
  localparam int Q_W         = Q_FRAC + 1;
  localparam int FIT_W       = 30;
  localparam int SQ1_W       = 2 * FIT_W;
  localparam int SQ_W        = SQ1_W + 2;
  localparam int RT_W        = SQ_W + 1;
  localparam int LEN_W       = FIT_W + 1;
  localparam int NUM_W       = FIT_W + Q_FRAC + 1;
  localparam int DEN_W       = LEN_W + Q_FRAC + 1;
  localparam int CNT_W       = 8;

  localparam int POS_STEPS   = 3;
  localparam int CROSS_STEPS = 6;
  localparam int SQ_STEPS    = 3;
  localparam int SQRT_STEPS  = SQ_W / 2 + 1;
  localparam int DIV_STEPS   = Q_W;
  localparam int MIN_CORNERS = 3;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_CORNER = 2'd1,
    FN_READ   = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_READ    = 2'd0,
    ST_APPLIED = 2'd1,
    ST_SHORT   = 2'd2,
    ST_LONG    = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_WRPOS, OP_CORNER, OP_ACC_RD, OP_ACC_LD, OP_POS,
    OP_EDGE, OP_CROSS, OP_FIT, OP_SQ, OP_SQRT, OP_DIV, OP_APPLY, OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ACC, S_FACE, S_POS, S_EDGE, S_CROSS, S_FIT, S_SQ,
    S_SQRT, S_DIV, S_APPLY, S_EMIT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       comp;
    stat_e            stat;
    logic             zero_n;
    logic             face_clr;
  } cmd_t;

  typedef struct packed {
    func_e             func;
    logic              last;
    logic [CCNT_W-1:0] count;
    logic              overflow;
  } sts_t;

endpackage
`default_nettype wire

>>> design/vna_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vna_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic [vna_pkg::IDX_W-1:0]           vertex_index;
  logic signed [vna_pkg::COORD_W-1:0]  pos_x;
  logic signed [vna_pkg::COORD_W-1:0]  pos_y;
  logic signed [vna_pkg::COORD_W-1:0]  pos_z;
  logic                                last_corner;
  modport source (output valid, func, vertex_index, pos_x, pos_y, pos_z, last_corner,
                  input ready);
  modport sink (input valid, func, vertex_index, pos_x, pos_y, pos_z, last_corner,
                output ready);
endinterface

interface vna_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [vna_pkg::IDX_W-1:0]       result_index;
  logic signed [vna_pkg::N_W-1:0]  normal_x;
  logic signed [vna_pkg::N_W-1:0]  normal_y;
  logic signed [vna_pkg::N_W-1:0]  normal_z;
  logic [1:0]                      face_status;
  modport source (output valid, result_index, normal_x, normal_y, normal_z, face_status,
                  input ready);
  modport sink (input valid, result_index, normal_x, normal_y, normal_z, face_status,
                output ready);
endinterface
`default_nettype wire

>>> design/vna_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module vna_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  wire             rsp_ready_i,
  input  vna_pkg::sts_t   sts_i,
  output vna_pkg::cmd_t   cmd_o
);
  import vna_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  stat_e            stat_q, stat_d;
  logic             zero_q, zero_d;
  logic             oval_q, oval_d;
  logic             emit_ok;

  assign emit_ok = !oval_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      stat_q  <= ST_READ;
      zero_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      stat_q  <= stat_d;
      zero_q  <= zero_d;
      oval_q  <= oval_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    comp_d       = comp_q;
    stat_d       = stat_q;
    zero_d       = zero_q;
    oval_d       = oval_q && !rsp_ready_i;
    req_ready_o  = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.cnt      = cnt_q;
    cmd_o.comp     = comp_q;
    cmd_o.stat     = stat_q;
    cmd_o.zero_n   = zero_q;
    cmd_o.face_clr = (stat_q != ST_READ);
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.func)
          FN_WRITE: begin
            cmd_o.op = OP_WRPOS;
            state_d  = S_IDLE;
          end
          FN_CORNER: begin
            cmd_o.op = OP_CORNER;
            state_d  = sts_i.last ? S_FACE : S_IDLE;
          end
          FN_READ: begin
            cmd_o.op = OP_ACC_RD;
            stat_d   = ST_READ;
            zero_d   = 1'b0;
            state_d  = S_ACC;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ACC: begin
        cmd_o.op = OP_ACC_LD;
        state_d  = S_FIT;
      end
      S_FACE: begin
        cnt_d = '0;
        if (sts_i.overflow) begin
          stat_d  = ST_LONG;
          zero_d  = 1'b1;
          state_d = S_EMIT;
        end else if (sts_i.count < CCNT_W'(MIN_CORNERS)) begin
          stat_d  = ST_SHORT;
          zero_d  = 1'b1;
          state_d = S_EMIT;
        end else begin
          stat_d  = ST_APPLIED;
          zero_d  = 1'b0;
          state_d = S_POS;
        end
      end
      S_POS: begin
        cmd_o.op = OP_POS;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(POS_STEPS)) begin
          cnt_d   = '0;
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd_o.op = OP_EDGE;
        state_d  = S_CROSS;
      end
      S_CROSS: begin
        cmd_o.op = OP_CROSS;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CROSS_STEPS)) begin
          cnt_d   = '0;
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        cmd_o.op = OP_FIT;
        cnt_d    = '0;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQ_STEPS)) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS)) begin
          cnt_d   = '0;
          comp_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS)) begin
          cnt_d = '0;
          if (comp_q == 2'd2) begin
            state_d = (stat_q == ST_APPLIED) ? S_APPLY : S_EMIT;
          end else begin
            comp_d = comp_q + 1'b1;
          end
        end
      end
      S_APPLY: begin
        cmd_o.op = OP_APPLY;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q[0] && (cnt_q[CIDX_W:1] == CIDX_W'(sts_i.count - 1'b1))) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          cmd_o.op = OP_EMIT;
          oval_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_o = oval_q;

  // an accepted request is dispatched in the next cycle
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == S_DISP)
    else $error("accepted request not dispatched");

  // face normals are only added into the accumulators for a face that qualifies
  a_apply_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |-> !sts_i.overflow && sts_i.count >= CCNT_W'(MIN_CORNERS))
    else $error("apply on an unqualified face");

  // a result is loaded into the output register only when it is free or its response is taken in that cycle
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_EMIT |=> rsp_valid_o && state_q == S_IDLE)
    else $error("emit did not present a response");

endmodule
`default_nettype wire

>>> design/vna_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module vna_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  vna_pkg::cmd_t                       cmd_i,
  output vna_pkg::sts_t                       sts_o,
  input  wire [1:0]                           func_i,
  input  wire [vna_pkg::IDX_W-1:0]            vertex_index_i,
  input  wire signed [vna_pkg::COORD_W-1:0]   pos_x_i,
  input  wire signed [vna_pkg::COORD_W-1:0]   pos_y_i,
  input  wire signed [vna_pkg::COORD_W-1:0]   pos_z_i,
  input  wire                                 last_corner_i,
  output logic [vna_pkg::IDX_W-1:0]           result_index_o,
  output logic signed [vna_pkg::N_W-1:0]      normal_x_o,
  output logic signed [vna_pkg::N_W-1:0]      normal_y_o,
  output logic signed [vna_pkg::N_W-1:0]      normal_z_o,
  output logic [1:0]                          face_status_o
);
  import vna_pkg::*;

  // latched request
  logic [1:0]                func_q;
  logic [IDX_W-1:0]          idx_q;
  logic [3*COORD_W-1:0]      pos_q;
  logic                      last_q;

  // face corner list
  logic [VIDX_W-1:0]         cbuf_q [MAX_CORNERS];
  logic [CCNT_W-1:0]         ccnt_q;
  logic                      ovf_q;

  // position and accumulator stores
  logic [3*COORD_W-1:0]      pos_mem [NUM_VERTS];
  logic [3*ACC_W-1:0]        sum_mem [NUM_VERTS];
  logic [3*COORD_W-1:0]      pos_rd_q;
  logic [3*ACC_W-1:0]        sum_rd_q;
  logic [VIDX_W-1:0]         pos_ra, sum_ra;
  logic                      sum_we;
  logic [3*ACC_W-1:0]        sum_wd;

  // arithmetic state
  logic [3*COORD_W-1:0]      p_q [3];
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [CROSS_W-1:0] vec_q [3];
  logic [FIT_W-1:0]          mag_q [3];
  logic [2:0]                neg_q;
  logic [SQ1_W-1:0]          sq_q;
  logic [SQ_W-1:0]           l2_q;
  logic [RT_W-1:0]           sv_q, sr_q, sb_q;
  logic [DEN_W-1:0]          rem_q, den_q;
  logic [Q_W-1:0]            quo_q;
  logic signed [N_W-1:0]     n_q [3];
  logic [IDX_W-1:0]          oidx_q;
  logic signed [N_W-1:0]     onx_q, ony_q, onz_q;
  logic [1:0]                ost_q;

  logic [CIDX_W-1:0]         apply_k;
  logic [2:0]                cross_k;
  logic [1:0]                cross_c;
  logic signed [EDGE_W-1:0]  mul_a, mul_b;
  logic [CROSS_W-1:0]        vmag [3];
  logic [CROSS_W-1:0]        vmax;
  logic [2:0]                fsh;
  logic [RT_W:0]             rt_t;
  logic [LEN_W-1:0]          len;
  logic [NUM_W-1:0]          num;
  logic [DEN_W-1:0]          rem_n;
  logic [Q_W-1:0]            quo_n;
  logic [1:0]                sqi;

  assign sts_o.func     = func_e'(func_q);
  assign sts_o.last     = last_q;
  assign sts_o.count    = ccnt_q;
  assign sts_o.overflow = ovf_q;

  assign apply_k = cmd_i.cnt[CIDX_W:1];
  assign pos_ra  = cbuf_q[cmd_i.cnt[CIDX_W-1:0]];
  // request vertex for a read or a position write, else the corner being applied
  assign sum_ra  = (cmd_i.op == OP_ACC_RD || cmd_i.op == OP_WRPOS) ? idx_q[VIDX_W-1:0]
                                                                   : cbuf_q[apply_k];
  assign len     = sr_q[LEN_W-1:0];

  // saturating add of the face normal into one accumulator, or a clear on a position write
  always_comb begin
    logic signed [ACC_W:0] s;
    sum_wd = '0;
    sum_we = 1'b0;
    for (int j = 0; j < 3; j++) begin
      s = ACC_W'(signed'(sum_rd_q[j*ACC_W +: ACC_W])) + (ACC_W+1)'(n_q[j]);
      if (s > (ACC_W+1)'(2**(ACC_W-1) - 1))      sum_wd[j*ACC_W +: ACC_W] = {1'b0, {(ACC_W-1){1'b1}}};
      else if (s < -(ACC_W+1)'(2**(ACC_W-1)))    sum_wd[j*ACC_W +: ACC_W] = {1'b1, {(ACC_W-1){1'b0}}};
      else                                       sum_wd[j*ACC_W +: ACC_W] = s[ACC_W-1:0];
    end
    if (cmd_i.op == OP_WRPOS) begin
      sum_wd = '0;
      sum_we = 1'b1;
    end else if (cmd_i.op == OP_APPLY && cmd_i.cnt[0]) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRPOS) pos_mem[idx_q[VIDX_W-1:0]] <= pos_q;
    pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_ra] <= sum_wd;
    sum_rd_q <= sum_mem[sum_ra];
  end

  // corner list control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccnt_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.op == OP_CORNER) begin
      if (ccnt_q < CCNT_W'(MAX_CORNERS)) ccnt_q <= ccnt_q + 1'b1;
      else                               ovf_q  <= 1'b1;
    end else if (cmd_i.op == OP_EMIT && cmd_i.face_clr) begin
      ccnt_q <= '0;
      ovf_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CORNER && ccnt_q < CCNT_W'(MAX_CORNERS))
      cbuf_q[ccnt_q[CIDX_W-1:0]] <= idx_q[VIDX_W-1:0];
  end

  // cross product operand selection
  assign cross_k = cmd_i.cnt[2:0];
  always_comb begin
    unique case (cross_k)
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
    endcase
  end
  assign cross_c = 2'((cross_k - 3'd1) >> 1);

  // magnitudes and the shift that brings the largest into the fit range
  always_comb begin
    for (int j = 0; j < 3; j++) vmag[j] = vec_q[j][CROSS_W-1] ? -vec_q[j] : vec_q[j];
    vmax = vmag[0];
    if (vmag[1] > vmax) vmax = vmag[1];
    if (vmag[2] > vmax) vmax = vmag[2];
    fsh = '0;
    for (int b = FIT_W; b < CROSS_W; b++) begin
      if (vmax[b]) fsh = 3'(b - FIT_W + 1);
    end
  end

  assign rt_t = {1'b0, sr_q} + {1'b0, sb_q};
  assign sqi  = cmd_i.cnt[1:0];

  // restoring division step
  assign num = {mag_q[cmd_i.comp], {Q_FRAC{1'b0}}} + NUM_W'(len >> 1);
  always_comb begin
    if (rem_q >= den_q) begin
      rem_n = rem_q - den_q;
      quo_n = {quo_q[Q_W-2:0], 1'b1};
    end else begin
      rem_n = rem_q;
      quo_n = {quo_q[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        func_q <= func_i;
        idx_q  <= vertex_index_i;
        pos_q  <= {pos_z_i, pos_y_i, pos_x_i};
        last_q <= last_corner_i;
      end
      OP_ACC_LD: begin
        for (int j = 0; j < 3; j++)
          vec_q[j] <= CROSS_W'(signed'(sum_rd_q[j*ACC_W +: ACC_W]));
      end
      OP_POS: begin
        if (cmd_i.cnt != '0) p_q[2'(cmd_i.cnt - 1'b1)] <= pos_rd_q;
      end
      OP_EDGE: begin
        for (int j = 0; j < 3; j++) begin
          e1_q[j] <= EDGE_W'(signed'(p_q[1][j*COORD_W +: COORD_W]))
                   - EDGE_W'(signed'(p_q[0][j*COORD_W +: COORD_W]));
          e2_q[j] <= EDGE_W'(signed'(p_q[2][j*COORD_W +: COORD_W]))
                   - EDGE_W'(signed'(p_q[0][j*COORD_W +: COORD_W]));
          vec_q[j] <= '0;
        end
      end
      OP_CROSS: begin
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cross_k != 3'd0) begin
          if (cross_k[0]) vec_q[cross_c] <= vec_q[cross_c] + CROSS_W'(prod_q);
          else            vec_q[cross_c] <= vec_q[cross_c] - CROSS_W'(prod_q);
        end
      end
      OP_FIT: begin
        for (int j = 0; j < 3; j++) begin
          mag_q[j] <= FIT_W'(vmag[j] >> fsh);
          neg_q[j] <= vec_q[j][CROSS_W-1];
        end
      end
      OP_SQ: begin
        if (sqi != 2'd3) sq_q <= mag_q[sqi] * mag_q[sqi];
        if (sqi == 2'd0) l2_q <= '0;
        else             l2_q <= l2_q + SQ_W'(sq_q);
      end
      OP_SQRT: begin
        if (cmd_i.cnt == '0) begin
          sv_q <= RT_W'(l2_q);
          sr_q <= '0;
          sb_q <= {1'b1, {(RT_W-1){1'b0}}};
        end else begin
          if ({1'b0, sv_q} >= rt_t) begin
            sv_q <= RT_W'({1'b0, sv_q} - rt_t);
            sr_q <= (sr_q >> 1) + sb_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sb_q <= sb_q >> 2;
        end
      end
      OP_DIV: begin
        if (cmd_i.cnt == '0) begin
          rem_q <= DEN_W'(num);
          den_q <= DEN_W'({len, {Q_FRAC{1'b0}}});
          quo_q <= '0;
        end else begin
          rem_q <= rem_n;
          den_q <= den_q >> 1;
          quo_q <= quo_n;
          if (cmd_i.cnt == CNT_W'(DIV_STEPS)) begin
            if (len == '0)               n_q[cmd_i.comp] <= '0;
            else if (neg_q[cmd_i.comp])  n_q[cmd_i.comp] <= -N_W'(quo_n);
            else                         n_q[cmd_i.comp] <= N_W'(quo_n);
          end
        end
      end
      OP_EMIT: begin
        oidx_q <= idx_q;
        onx_q  <= cmd_i.zero_n ? '0 : n_q[0];
        ony_q  <= cmd_i.zero_n ? '0 : n_q[1];
        onz_q  <= cmd_i.zero_n ? '0 : n_q[2];
        ost_q  <= cmd_i.stat;
      end
      default: ;
    endcase
  end

  assign result_index_o = oidx_q;
  assign normal_x_o     = onx_q;
  assign normal_y_o     = ony_q;
  assign normal_z_o     = onz_q;
  assign face_status_o  = ost_q;

endmodule
`default_nettype wire

>>> design/vertex_normal_accumulate_unit.sv
// steps: a position write, or a corner that does not end a face, is accepted and dispatched;
// a read walks accept, dispatch, store read, fit, 4 square, 33 root steps,
// 3 x 16 divide steps, emit; a face end adds the position fetch and cross product
// steps plus an accumulator read and write per corner
// throughput: one request at a time, set by the shared root and divide sequence
// the output register lets the next request enter while a response waits
// reset (async, active low) clears the controller and corner count; stores need no clear
`timescale 1ns / 1ps
`default_nettype none
module vertex_normal_accumulate_unit (
  input  wire       clk_i,
  input  wire       rst_ni,
  vna_req_if.sink   req_i,
  vna_rsp_if.source rsp_o
);
  import vna_pkg::*;

  // command and status between the sequencer and the arithmetic
  cmd_t cmd;
  sts_t sts;

  // controller: accepts requests, walks the normalize and apply steps
  vna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: stores, cross product, fit, root, divide, saturating accumulate
  vna_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (req_i.func),
    .vertex_index_i (req_i.vertex_index),
    .pos_x_i        (req_i.pos_x),
    .pos_y_i        (req_i.pos_y),
    .pos_z_i        (req_i.pos_z),
    .last_corner_i  (req_i.last_corner),
    .result_index_o (rsp_o.result_index),
    .normal_x_o     (rsp_o.normal_x),
    .normal_y_o     (rsp_o.normal_y),
    .normal_z_o     (rsp_o.normal_z),
    .face_status_o  (rsp_o.face_status)
  );

endmodule
`default_nettype wire
